### rtl/core/swssc_pkg.sv
// Package for the stopwatch seven-segment clock: widths, request codes,
// digit chain radices and reset digits, and the seven-segment encoder.
// No dependencies; every other file in rtl/core imports it.
package swssc_pkg;

    localparam int CNT_W   = 32;
    localparam int STAMP_W = 16;
    localparam int SEG_W   = 8;
    localparam int DIGIT_W = 4;
    localparam int NUM_DIGITS = 6;
    localparam int CONV_W  = $clog2(CNT_W + 1);

    // Register reset values.
    localparam logic [STAMP_W-1:0] THRESHOLD_RESET = 16'd32768;
    localparam logic [CNT_W-1:0]   START_RESET     = 32'd356350;

    // Register indexes on the configuration port.
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_START     = 1'b1;

    // Request codes carried in req_type.
    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_PRESS   = 2'd1,
        REQ_RELEASE = 2'd2
    } req_type_t;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digit_vec_t;

    // Commands from the control logic to the digit chain.
    typedef struct packed {
        logic clear;   // set every digit to zero
        logic incr;    // add one second
        logic load;    // rebuild the digits from a binary value
    } chain_cmd_t;

    // Digits from the bottom: sec ones, sec tens, min ones, min tens,
    // hour ones, hour tens. Hours wrap at 100, so the chain holds the
    // count modulo 360000.
    localparam int DIGIT_RADIX [NUM_DIGITS] = '{10, 6, 10, 6, 10, 10};

    localparam int START_SEC  = int'(START_RESET % 60);
    localparam int START_MIN  = int'((START_RESET / 60) % 60);
    localparam int START_HOUR = int'((START_RESET / 3600) % 100);

    localparam int DIGIT_RESET [NUM_DIGITS] = '{
        START_SEC % 10, START_SEC / 10,
        START_MIN % 10, START_MIN / 10,
        START_HOUR % 10, START_HOUR / 10
    };

    // Seven-segment code of one decimal digit.
    function automatic logic [SEG_W-1:0] seg_code(input digit_t d);
        logic [SEG_W-1:0] code;
        case (d)
            4'd0:    code = 8'hFC;
            4'd1:    code = 8'h60;
            4'd2:    code = 8'hDB;
            4'd3:    code = 8'hF3;
            4'd4:    code = 8'h67;
            4'd5:    code = 8'hB7;
            4'd6:    code = 8'hBF;
            4'd7:    code = 8'hE0;
            4'd8:    code = 8'hFF;
            4'd9:    code = 8'hE7;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

### rtl/core/swssc_if.sv
// Handshake channels of the stopwatch: the request channel and the result
// channel, each with valid, ready and payload. Depends on swssc_pkg.
interface swssc_req_if
    import swssc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [STAMP_W-1:0] stamp;

    modport source (output valid, output req_type, output stamp, input ready);
    modport sink (input valid, input req_type, input stamp, output ready);
endinterface

interface swssc_res_if
    import swssc_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [SEG_W-1:0] seg_hour_tens;
    logic [SEG_W-1:0] seg_hour_ones;
    logic [SEG_W-1:0] seg_min_tens;
    logic [SEG_W-1:0] seg_min_ones;
    logic [SEG_W-1:0] seg_sec_tens;
    logic [SEG_W-1:0] seg_sec_ones;
    logic [CNT_W-1:0] elapsed;
    logic             running;

    modport source (
        output valid, input ready,
        output seg_hour_tens, output seg_hour_ones, output seg_min_tens,
        output seg_min_ones, output seg_sec_tens, output seg_sec_ones,
        output elapsed, output running
    );
    modport sink (
        input valid, output ready,
        input seg_hour_tens, input seg_hour_ones, input seg_min_tens,
        input seg_min_ones, input seg_sec_tens, input seg_sec_ones,
        input elapsed, input running
    );
endinterface

### rtl/core/swssc_digit_cell.sv
// One digit cell of the display chain: holds a digit of a given radix and
// either adds a carry or doubles and adds a carry. Depends on swssc_pkg.
module swssc_digit_cell
    import swssc_pkg::*;
#(
    parameter int RADIX       = 10,
    parameter int RESET_DIGIT = 0
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   clear,
    input  logic   step,
    input  logic   dbl,
    input  logic   cin,
    output digit_t digit,
    output logic   cout
);

    digit_t             digit_reg;
    digit_t             digit_next;
    logic [DIGIT_W:0]   sum;
    logic               wrap;

    // The digit stays below the radix, so one subtract brings any sum back.
    always_comb
    begin
        sum  = (dbl ? {digit_reg, 1'b0} : {1'b0, digit_reg}) + {{DIGIT_W{1'b0}}, cin};
        wrap = (sum >= (DIGIT_W + 1)'(RADIX));
        digit_next = wrap ? DIGIT_W'(sum - (DIGIT_W + 1)'(RADIX)) : DIGIT_W'(sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= DIGIT_W'(RESET_DIGIT);
        end
        else if (clear)
        begin
            digit_reg <= '0;
        end
        else if (step)
        begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;
    assign cout  = step && wrap;

endmodule

### rtl/core/swssc_digit_chain.sv
// Row of digit cells that keeps HH:MM:SS of the seconds count, with the
// sequencer that rebuilds it from a binary value one bit per cycle.
// Depends on swssc_pkg and swssc_digit_cell.
module swssc_digit_chain
    import swssc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  chain_cmd_t       cmd,
    input  logic [CNT_W-1:0] load_value,
    output digit_vec_t       digits,
    output logic             busy
);

    logic [CNT_W-1:0]      shift_reg;
    logic [CNT_W-1:0]      shift_next;
    logic [CONV_W-1:0]     conv_cnt_reg;
    logic [CONV_W-1:0]     conv_cnt_next;
    logic [NUM_DIGITS-1:0] carry;
    logic                  cell_clear;
    logic                  cell_step;

    assign busy = (conv_cnt_reg != '0);

    // Conversion sequencer: the value enters MSB first, and each cycle the
    // chain doubles its contents and adds the next bit.
    always_comb
    begin
        shift_next    = shift_reg;
        conv_cnt_next = conv_cnt_reg;
        if (cmd.load)
        begin
            shift_next    = load_value;
            conv_cnt_next = CONV_W'(CNT_W);
        end
        else if (busy)
        begin
            shift_next    = {shift_reg[CNT_W-2:0], 1'b0};
            conv_cnt_next = conv_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_cnt_reg <= '0;
        end
        else
        begin
            conv_cnt_reg <= conv_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    assign cell_clear = cmd.clear || cmd.load;
    assign cell_step  = busy || cmd.incr;
    assign carry[0]   = busy ? shift_reg[CNT_W-1] : 1'b1;

    // The carry out of the hour tens cell is the wrap of hours at 100 and
    // is dropped.
    for (genvar i = 0; i < NUM_DIGITS; i++)
    begin : g_cell
        if (i < NUM_DIGITS - 1)
        begin : g_mid
            swssc_digit_cell #(
                .RADIX       (DIGIT_RADIX[i]),
                .RESET_DIGIT (DIGIT_RESET[i])
            ) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .clear (cell_clear),
                .step  (cell_step),
                .dbl   (busy),
                .cin   (carry[i]),
                .digit (digits[i]),
                .cout  (carry[i+1])
            );
        end
        else
        begin : g_top
            swssc_digit_cell #(
                .RADIX       (DIGIT_RADIX[i]),
                .RESET_DIGIT (DIGIT_RESET[i])
            ) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .clear (cell_clear),
                .step  (cell_step),
                .dbl   (busy),
                .cin   (carry[i]),
                .digit (digits[i]),
                .cout  ()
            );
        end
    end

endmodule

### rtl/core/stopwatch_seven_segment_clock.sv
// Seconds stopwatch with an HH:MM:SS seven-segment readout. One request
// (tick, button press or button release) is accepted per cycle, and its
// result stands in the output register from the next cycle on, so the
// block runs at one request per cycle while results are taken. The display
// digits live in a chain of six digit cells that count alongside the
// binary seconds count. A write to start_count rebuilds the digits from
// the binary value, one bit per cycle through the chain; no request is
// accepted in that time. Reset needs no such pass.
// Depends on swssc_pkg, swssc_if and swssc_digit_chain.
module stopwatch_seven_segment_clock
    import swssc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    swssc_req_if.sink          req,
    swssc_res_if.source        res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [STAMP_W-1:0] threshold_reg;
    logic [CNT_W-1:0]   start_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               run_reg;
    logic               run_next;
    logic               held_reg;
    logic               held_next;
    logic [STAMP_W-1:0] press_reg;
    logic [STAMP_W-1:0] press_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic               in_fire;
    logic               cfg_wr;
    logic               start_wr;
    logic [STAMP_W-1:0] hold;
    chain_cmd_t         cmd;
    digit_vec_t         digits;
    logic               chain_busy;

    // Configuration port.
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign start_wr = cfg_wr && (paddr[2] == REG_START);
    assign prdata   = (paddr[2] == REG_START) ? start_reg
                                              : {{(32 - STAMP_W){1'b0}}, threshold_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            start_reg     <= START_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_THRESHOLD)
            begin
                threshold_reg <= pwdata[STAMP_W-1:0];
            end
            else
            begin
                start_reg <= pwdata;
            end
        end
    end

    // Request handshake: the output register frees up as its result leaves.
    assign req.ready = !chain_busy && (!out_valid_reg || res.ready);
    assign in_fire   = req.valid && req.ready;
    assign hold      = req.stamp - press_reg;

    // Next state of the stopwatch and commands to the digit chain.
    always_comb
    begin
        count_next = count_reg;
        run_next   = run_reg;
        held_next  = held_reg;
        press_next = press_reg;
        cmd        = '0;
        if (start_wr)
        begin
            count_next = pwdata;
            cmd.load   = 1'b1;
        end
        else if (in_fire)
        begin
            case (req.req_type)
                REQ_TICK:
                begin
                    if (run_reg)
                    begin
                        count_next = count_reg + 1'b1;
                        // The binary count wraps to zero, and so must the digits.
                        if (count_reg == '1)
                        begin
                            cmd.clear = 1'b1;
                        end
                        else
                        begin
                            cmd.incr = 1'b1;
                        end
                    end
                end
                REQ_PRESS:
                begin
                    if (!held_reg)
                    begin
                        press_next = req.stamp;
                        held_next  = 1'b1;
                    end
                end
                REQ_RELEASE:
                begin
                    if (held_reg)
                    begin
                        held_next = 1'b0;
                        if (hold > threshold_reg)
                        begin
                            count_next = '0;
                            cmd.clear  = 1'b1;
                        end
                        else
                        begin
                            run_next = !run_reg;
                        end
                    end
                end
                default:
                begin
                    // Unused code: the current display is returned.
                end
            endcase
        end
    end

    // Result valid flag.
    always_comb
    begin
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= START_RESET;
            run_reg       <= 1'b1;
            held_reg      <= 1'b0;
            press_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            run_reg       <= run_next;
            held_reg      <= held_next;
            press_reg     <= press_next;
            out_valid_reg <= out_valid_next;
        end
    end

    swssc_digit_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .load_value (pwdata),
        .digits     (digits),
        .busy       (chain_busy)
    );

    // The state registers hold the result of the last request until the
    // next one is accepted or start_count is written.
    assign res.valid         = out_valid_reg;
    assign res.seg_sec_ones  = seg_code(digits[0]);
    assign res.seg_sec_tens  = seg_code(digits[1]);
    assign res.seg_min_ones  = seg_code(digits[2]);
    assign res.seg_min_tens  = seg_code(digits[3]);
    assign res.seg_hour_ones = seg_code(digits[4]);
    assign res.seg_hour_tens = seg_code(digits[5]);
    assign res.elapsed       = count_reg;
    assign res.running       = run_reg;

`ifndef NO_ASSERTIONS
    // No request may enter while the digits are being rebuilt.
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        chain_busy |-> !req.ready)
        else $error("request accepted during digit rebuild");

    // A running tick at the top of the count wraps to zero.
    a_count_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !start_wr && req.req_type == REQ_TICK && run_reg && count_reg == '1)
        |=> (count_reg == '0))
        else $error("seconds count did not wrap");

    // The run flag changes only on an accepted release.
    a_run_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(run_reg) |-> $past(in_fire && req.req_type == REQ_RELEASE && held_reg))
        else $error("run flag changed without a release");
`endif

endmodule

### sim/swssc_checker.sv
// Scoreboard for the stopwatch seven-segment clock: tracks register writes,
// predicts the HH:MM:SS readout of every accepted request and compares it.
// Depends on swssc_pkg and the swssc_req_if / swssc_res_if channels.
module swssc_checker
    import swssc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    swssc_req_if        req,
    swssc_res_if        res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // One predicted readout as the result channel should present it.
    typedef struct {
        logic [SEG_W-1:0] hour_tens;
        logic [SEG_W-1:0] hour_ones;
        logic [SEG_W-1:0] min_tens;
        logic [SEG_W-1:0] min_ones;
        logic [SEG_W-1:0] sec_tens;
        logic [SEG_W-1:0] sec_ones;
        logic [CNT_W-1:0] elapsed;
        logic             running;
    } readout_t;

    // Segment patterns of the decimal digits 0 to 9.
    localparam logic [SEG_W-1:0] DIGIT_SEGS [10] = '{
        8'hFC, 8'h60, 8'hDB, 8'hF3, 8'h67, 8'hB7, 8'hBF, 8'hE0, 8'hFF, 8'hE7
    };

    // Shadow copy of the registers and of the stopwatch state.
    logic [STAMP_W-1:0] threshold_reg;
    logic [CNT_W-1:0]   start_reg;
    logic [CNT_W-1:0]   seconds;
    logic               run_on;
    logic               key_down;
    logic [STAMP_W-1:0] press_time;
    logic [STAMP_W-1:0] hold_time;
    int                 sec_part;
    int                 min_part;
    int                 hour_part;
    readout_t           predicted;
    readout_t           observed;
    readout_t           readout_queue [$];

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg = THRESHOLD_RESET;
            start_reg     = START_RESET;
            seconds       = START_RESET;
            run_on        = 1'b1;
            key_down      = 1'b0;
            press_time    = '0;
            readout_queue.delete();
            outstanding   = 0;
        end
        else
        begin
            // A result leaves the block: compare it with the oldest prediction.
            if (res.valid && res.ready)
            begin
                if (readout_queue.size() == 0)
                begin
                    $error("result arrived with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    predicted = readout_queue.pop_front();
                    observed.hour_tens = res.seg_hour_tens;
                    observed.hour_ones = res.seg_hour_ones;
                    observed.min_tens  = res.seg_min_tens;
                    observed.min_ones  = res.seg_min_ones;
                    observed.sec_tens  = res.seg_sec_tens;
                    observed.sec_ones  = res.seg_sec_ones;
                    observed.elapsed   = res.elapsed;
                    observed.running   = res.running;
                    check_field("seg_hour_tens", predicted.hour_tens, observed.hour_tens);
                    check_field("seg_hour_ones", predicted.hour_ones, observed.hour_ones);
                    check_field("seg_min_tens", predicted.min_tens, observed.min_tens);
                    check_field("seg_min_ones", predicted.min_ones, observed.min_ones);
                    check_field("seg_sec_tens", predicted.sec_tens, observed.sec_tens);
                    check_field("seg_sec_ones", predicted.sec_ones, observed.sec_ones);
                    check_field("elapsed", predicted.elapsed, observed.elapsed);
                    check_field("running", predicted.running, observed.running);
                end
            end

            // Register access: a write to start_count also reloads the count.
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[2] == REG_START)
                    begin
                        start_reg = pwdata;
                        seconds   = pwdata;
                    end
                    else
                    begin
                        threshold_reg = pwdata[STAMP_W-1:0];
                    end
                end
                else if (paddr[2] == REG_START)
                begin
                    check_field("prdata", start_reg, prdata);
                end
                else
                begin
                    check_field("prdata", {16'h0, threshold_reg}, prdata);
                end
            end

            // A request enters the block: advance the shadow state.
            if (req.valid && req.ready)
            begin
                case (req.req_type)
                    REQ_TICK:
                    begin
                        if (run_on)
                            seconds = seconds + 1'b1;
                    end
                    REQ_PRESS:
                    begin
                        if (!key_down)
                        begin
                            press_time = req.stamp;
                            key_down   = 1'b1;
                        end
                    end
                    REQ_RELEASE:
                    begin
                        if (key_down)
                        begin
                            hold_time = req.stamp - press_time;
                            key_down  = 1'b0;
                            if (hold_time > threshold_reg)
                                seconds = '0;
                            else
                                run_on = !run_on;
                        end
                    end
                    default:
                    begin
                        // The unused code changes nothing but still reports.
                    end
                endcase

                sec_part  = int'(seconds % 60);
                min_part  = int'((seconds / 60) % 60);
                hour_part = int'((seconds / 3600) % 100);
                predicted.hour_tens = DIGIT_SEGS[hour_part / 10];
                predicted.hour_ones = DIGIT_SEGS[hour_part % 10];
                predicted.min_tens  = DIGIT_SEGS[min_part / 10];
                predicted.min_ones  = DIGIT_SEGS[min_part % 10];
                predicted.sec_tens  = DIGIT_SEGS[sec_part / 10];
                predicted.sec_ones  = DIGIT_SEGS[sec_part % 10];
                predicted.elapsed   = seconds;
                predicted.running   = run_on;
                readout_queue.push_back(predicted);
            end

            outstanding = readout_queue.size();
        end
    end

endmodule

### sim/stopwatch_seven_segment_clock_tb.sv
// Top of the stopwatch testbench: clock, reset, register setup, directed and
// random request streams with handshake stalls, and the final verdict.
// Depends on swssc_pkg, the swssc channels, the block and swssc_checker.
module stopwatch_seven_segment_clock_tb
    import swssc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // The request code that the block must accept and ignore.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Register settings per random block; every fourth one is drawn at random.
    localparam logic [15:0] THR_PICK [12] = '{
        16'd32768, 16'd0, 16'd65535, 16'd0, 16'd1, 16'd65534,
        16'd100, 16'd0, 16'd0, 16'd65535, 16'd5, 16'd0
    };
    localparam logic [31:0] START_PICK [12] = '{
        32'd0, 32'hFFFF_FFFF, 32'd359999, 32'd0, 32'hFFFF_FFF0, 32'd3599,
        32'd359940, 32'd0, 32'd86399, 32'd0, 32'hFFFF_FFC5, 32'd0
    };

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          mismatches;
    int          outstanding;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          items_sent;
    logic [15:0] thr_now;

    swssc_req_if req_ch ();
    swssc_res_if res_ch ();

    stopwatch_seven_segment_clock dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    swssc_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .res         (res_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 20 ns clock.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // The result side stalls at random, at the rate of the current phase.
    always @(negedge clk)
    begin
        res_ch.ready <= rst_n ? ($urandom_range(99) >= recv_idle_pct) : 1'b0;
    end

    // Hard limit on the run time.
    initial
    begin
        #4_000_000;
        $display("stopwatch_seven_segment_clock_tb: done, errors");
        $finish;
    end

    // Offer one request, after a random number of idle cycles; called and
    // returning at a falling edge, with valid left high for the next request.
    task automatic send_req(input logic [1:0] kind, input logic [15:0] st);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.stamp    <= st;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
        @(negedge clk);
    endtask

    // Hold requests back until every result is in and the block is quiet.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_access(input logic reg_idx, input logic wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Idle the block, write both registers and read them back.
    task automatic configure(input logic [15:0] thr, input logic [31:0] start_val);
        drain();
        apb_access(REG_THRESHOLD, 1'b1, {16'($urandom), thr});
        apb_access(REG_START, 1'b1, start_val);
        apb_access(REG_THRESHOLD, 1'b0, 32'h0);
        apb_access(REG_START, 1'b0, 32'h0);
        thr_now = thr;
    endtask

    // Mostly ticks and press/release pairs with holds around the threshold,
    // the rest lone presses, lone releases and the unused code.
    task automatic run_burst(input int count);
        int          stop_at;
        int          pick;
        logic [15:0] t_press;
        logic [15:0] hold;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                send_req(REQ_TICK, 16'($urandom));
            end
            else if (pick < 85)
            begin
                t_press = 16'($urandom);
                case ($urandom_range(4))
                    0:       hold = thr_now - 16'd1;
                    1:       hold = thr_now;
                    2:       hold = thr_now + 16'd1;
                    3:       hold = 16'($urandom_range(50));
                    default: hold = 16'($urandom);
                endcase
                send_req(REQ_PRESS, t_press);
                repeat ($urandom_range(2)) send_req(REQ_TICK, 16'($urandom));
                send_req(REQ_RELEASE, t_press + hold);
            end
            else if (pick < 92)
            begin
                send_req(REQ_PRESS, 16'($urandom));
            end
            else if (pick < 97)
            begin
                send_req(REQ_RELEASE, 16'($urandom));
            end
            else
            begin
                send_req(REQ_UNUSED, 16'($urandom));
            end
        end
    endtask

    initial
    begin
        int k;
        logic [15:0] thr_val;
        logic [31:0] start_val;

        // Every input known from time zero; reset held low, then released at a falling edge.
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_TICK;
        req_ch.stamp    = '0;
        res_ch.ready    = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        items_sent      = 0;
        thr_now         = THRESHOLD_RESET;
        send_idle_pct   = 23;
        recv_idle_pct   = 64;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests on the reset settings.
        send_req(REQ_TICK, 16'h0000);
        send_req(REQ_TICK, 16'hFFFF);
        // Hold that wraps past zero, one below the threshold: pause.
        send_req(REQ_PRESS, 16'hFFFF);
        send_req(REQ_RELEASE, 16'h7FFE);
        send_req(REQ_TICK, 16'hAAAA);
        // Second press while held is ignored; hold equal to threshold resumes.
        send_req(REQ_PRESS, 16'h1000);
        send_req(REQ_PRESS, 16'h2000);
        send_req(REQ_RELEASE, 16'h9000);
        // Release with the button up is ignored.
        send_req(REQ_RELEASE, 16'h5555);
        // Hold one above the threshold clears the count.
        send_req(REQ_PRESS, 16'h0000);
        send_req(REQ_RELEASE, 16'h8001);
        send_req(REQ_UNUSED, 16'hFFFF);
        send_req(REQ_TICK, 16'h5555);

        // Count wrap, then zero threshold: zero hold toggles, any longer hold clears.
        configure(16'h0000, 32'hFFFF_FFFE);
        send_req(REQ_TICK, 16'h0001);
        send_req(REQ_TICK, 16'h0002);
        send_req(REQ_TICK, 16'h0003);
        send_req(REQ_PRESS, 16'h0005);
        send_req(REQ_RELEASE, 16'h0005);
        send_req(REQ_PRESS, 16'h0005);
        send_req(REQ_RELEASE, 16'h0006);

        // Largest threshold: the longest hold still toggles; hours roll past 99.
        configure(16'hFFFF, 32'd359999);
        send_req(REQ_PRESS, 16'h0000);
        send_req(REQ_RELEASE, 16'hFFFF);
        send_req(REQ_TICK, 16'h0000);

        // Random part in three stall phases, four register settings each.
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 64 : 0;
            recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 23 : 0;
            for (int blk = 0; blk < 4; blk++)
            begin
                k = phase * 4 + blk;
                thr_val   = (blk == 3) ? 16'($urandom) : THR_PICK[k];
                start_val = (blk == 3) ? 32'($urandom) : START_PICK[k];
                configure(thr_val, start_val);
                run_burst(140);
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("stopwatch_seven_segment_clock_tb: done, clean");
        else
            $display("stopwatch_seven_segment_clock_tb: done, errors");
        $finish;
    end

endmodule
